FILE: rtl/spi_pkg.sv
// Shared types and constants for the segment / plane intersection block.
// Used by spi_front, spi_back and segment_plane_intersect_top.
package spi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 33;                 // difference of two coordinates
  localparam int PW        = 65;                 // 32 x 33 product
  localparam int NUM_W     = 67;                 // sum of three products
  localparam int QB        = 32;                 // quotient bits before saturation
  localparam int RW        = NUM_W + QB;         // divider remainder width
  localparam int Q_DEPTH   = 8;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int O_DEPTH   = 64;
  localparam int O_AW      = $clog2(O_DEPTH);

  localparam logic [2:0] REG_NORMAL_X = 3'd0;
  localparam logic [2:0] REG_NORMAL_Y = 3'd1;
  localparam logic [2:0] REG_NORMAL_Z = 3'd2;
  localparam logic [2:0] REG_ANCHOR_X = 3'd3;
  localparam logic [2:0] REG_ANCHOR_Y = 3'd4;
  localparam logic [2:0] REG_ANCHOR_Z = 3'd5;

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } seg_t;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic               parallel;
  } hit_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic [2:0][31:0]   s;
    logic [2:0][DW-1:0] d;
    logic [NUM_W-1:0]   absnum;
    logic [NUM_W-1:0]   absden;
    logic               neg;
    logic               par;
  } job_t;

endpackage

FILE: rtl/spi_front.sv
// Front end: plane registers, dot products, classification and the job queue.
// Depends on spi_pkg.
module spi_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  spi_pkg::seg_t segment,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [31:0]   wr_data,
  input  logic          q_pop,
  output logic          q_empty,
  output spi_pkg::job_t q_head
);

  logic [2:0][31:0] normal;
  logic [2:0][31:0] anchor;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal[0] <= '0;
      normal[1] <= '0;
      normal[2] <= 32'(1) << spi_pkg::FRAC_BITS;
      anchor    <= '0;
    end else if (wr_en) begin
      case (wr_index)
        spi_pkg::REG_NORMAL_X: normal[0] <= wr_data;
        spi_pkg::REG_NORMAL_Y: normal[1] <= wr_data;
        spi_pkg::REG_NORMAL_Z: normal[2] <= wr_data;
        spi_pkg::REG_ANCHOR_X: anchor[0] <= wr_data;
        spi_pkg::REG_ANCHOR_Y: anchor[1] <= wr_data;
        spi_pkg::REG_ANCHOR_Z: anchor[2] <= wr_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = push && !full;

  logic [2:0][31:0] s_in, e_in;
  assign s_in = {segment.start_z, segment.start_y, segment.start_x};
  assign e_in = {segment.end_z, segment.end_y, segment.end_x};

  // Stage 1: differences.
  logic                          v1;
  logic [2:0][31:0]              s1;
  logic [2:0][spi_pkg::DW-1:0]   d1, pa1;
  // Stage 2: products.
  logic                          v2;
  logic [2:0][31:0]              s2;
  logic [2:0][spi_pkg::DW-1:0]   d2;
  logic [2:0][spi_pkg::PW-1:0]   pn2, pd2;
  // Stage 3: sums.
  logic                          v3;
  logic [2:0][31:0]              s3;
  logic [2:0][spi_pkg::DW-1:0]   d3;
  logic [spi_pkg::NUM_W-1:0]     num3, den3;
  // Stage 4: magnitudes and flags.
  logic                          v4;
  spi_pkg::job_t                 job4;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s1[k]  <= s_in[k];
      d1[k]  <= {e_in[k][31], e_in[k]} - {s_in[k][31], s_in[k]};
      pa1[k] <= {anchor[k][31], anchor[k]} - {s_in[k][31], s_in[k]};
      pn2[k] <= spi_pkg::PW'($signed(normal[k]) * $signed(pa1[k]));
      pd2[k] <= spi_pkg::PW'($signed(normal[k]) * $signed(d1[k]));
    end
    s2 <= s1;
    d2 <= d1;
    s3 <= s2;
    d3 <= d2;
    num3 <= {{2{pn2[0][64]}}, pn2[0]} + {{2{pn2[1][64]}}, pn2[1]}
          + {{2{pn2[2][64]}}, pn2[2]};
    den3 <= {{2{pd2[0][64]}}, pd2[0]} + {{2{pd2[1][64]}}, pd2[1]}
          + {{2{pd2[2][64]}}, pd2[2]};
    job4.s      <= s3;
    job4.d      <= d3;
    job4.absnum <= num3[spi_pkg::NUM_W-1] ? -num3 : num3;
    job4.absden <= den3[spi_pkg::NUM_W-1] ? -den3 : den3;
    job4.neg    <= num3[spi_pkg::NUM_W-1] ^ den3[spi_pkg::NUM_W-1];
    job4.par    <= (den3 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Job queue. The occupancy count also covers items still in the stages
  // above, so the queue can never overflow.
  spi_pkg::job_t           mem [spi_pkg::Q_DEPTH];
  logic [spi_pkg::Q_AW-1:0] wp, rp;
  logic [spi_pkg::Q_AW:0]   stored, occ;
  logic                     do_pop;

  assign do_pop  = q_pop && !q_empty;
  assign q_empty = (stored == '0);
  assign q_head  = mem[rp];
  assign full    = (occ == (spi_pkg::Q_AW+1)'(spi_pkg::Q_DEPTH));

  always_ff @(posedge clk) begin
    if (v4) begin
      mem[wp] <= job4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp     <= '0;
      rp     <= '0;
      stored <= '0;
      occ    <= '0;
    end else begin
      if (v4) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      stored <= stored + (spi_pkg::Q_AW+1)'(v4) - (spi_pkg::Q_AW+1)'(do_pop);
      occ    <= occ + (spi_pkg::Q_AW+1)'(accept) - (spi_pkg::Q_AW+1)'(do_pop);
    end
  end

endmodule

FILE: rtl/spi_back.sv
// Back end: pipelined divider for t, saturation, the hit point and the result queue.
// Depends on spi_pkg.
module spi_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  spi_pkg::job_t q_head,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output spi_pkg::hit_t hit
);

  typedef struct packed {
    logic                        v;
    logic [spi_pkg::RW-1:0]      r;
    logic [spi_pkg::NUM_W-1:0]   b;
    logic [spi_pkg::QB-1:0]      q;
    logic                        ovf;
    logic                        neg;
    logic                        par;
    logic [2:0][31:0]            s;
    logic [2:0][spi_pkg::DW-1:0] d;
  } div_t;

  logic                     out_pop;
  logic [spi_pkg::O_AW:0]   tot;

  assign out_pop = pop && !empty;
  // Space is reserved in the result queue for every item in the pipeline.
  assign q_pop   = !q_empty && (tot != (spi_pkg::O_AW+1)'(spi_pkg::O_DEPTH));

  div_t dv [spi_pkg::QB+1];

  logic [spi_pkg::RW-1:0] a0, bsh0;
  assign a0   = spi_pkg::RW'({q_head.absnum, {spi_pkg::FRAC_BITS{1'b0}}});
  assign bsh0 = spi_pkg::RW'(q_head.absden) << spi_pkg::QB;

  // An item whose quotient needs more than 32 bits saturates; this also
  // covers a zero denominator, which is resolved as the parallel case.
  always_ff @(posedge clk) begin
    dv[0].v   <= rst ? 1'b0 : q_pop;
    dv[0].r   <= a0;
    dv[0].b   <= q_head.absden;
    dv[0].q   <= '0;
    dv[0].ovf <= (a0 >= bsh0);
    dv[0].neg <= q_head.neg;
    dv[0].par <= q_head.par;
    dv[0].s   <= q_head.s;
    dv[0].d   <= q_head.d;
  end

  for (genvar i = 0; i < spi_pkg::QB; i++) begin : g_div
    logic [spi_pkg::RW-1:0] sh;
    logic                   ge;
    assign sh = spi_pkg::RW'(dv[i].b) << (spi_pkg::QB - 1 - i);
    assign ge = (dv[i].r >= sh);
    always_ff @(posedge clk) begin
      dv[i+1].v   <= rst ? 1'b0 : dv[i].v;
      dv[i+1].r   <= ge ? dv[i].r - sh : dv[i].r;
      dv[i+1].b   <= dv[i].b;
      dv[i+1].q   <= {dv[i].q[spi_pkg::QB-2:0], ge};
      dv[i+1].ovf <= dv[i].ovf;
      dv[i+1].neg <= dv[i].neg;
      dv[i+1].par <= dv[i].par;
      dv[i+1].s   <= dv[i].s;
      dv[i+1].d   <= dv[i].d;
    end
  end

  // Clamp t.
  logic                        vc;
  logic [31:0]                 tc;
  logic [2:0][31:0]            sc;
  logic [2:0][spi_pkg::DW-1:0] dc;
  logic                        pc;
  logic [31:0]                 qf;
  assign qf = dv[spi_pkg::QB].q;

  always_ff @(posedge clk) begin
    if (dv[spi_pkg::QB].par) begin
      tc <= '0;
    end else if (dv[spi_pkg::QB].neg) begin
      if (dv[spi_pkg::QB].ovf || (qf > 32'h8000_0000)) tc <= 32'h8000_0000;
      else tc <= -qf;
    end else begin
      if (dv[spi_pkg::QB].ovf || qf[31]) tc <= 32'h7FFF_FFFF;
      else tc <= qf;
    end
    sc <= dv[spi_pkg::QB].s;
    dc <= dv[spi_pkg::QB].d;
    pc <= dv[spi_pkg::QB].par;
  end

  // Multiply by the direction.
  logic                        vm;
  logic [2:0][spi_pkg::PW-1:0] pm;
  logic [2:0][31:0]            sm;
  logic                        pmr;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pm[k] <= spi_pkg::PW'($signed(tc) * $signed(dc[k]));
    end
    sm  <= sc;
    pmr <= pc;
  end

  // Shift, add the start point and saturate.
  logic          vf;
  spi_pkg::hit_t hf;
  logic [2:0][spi_pkg::PW:0] sumk;
  logic [2:0][31:0]          satk;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sumk[k] = $signed({pm[k][spi_pkg::PW-1], pm[k]}) >>> spi_pkg::FRAC_BITS;
      sumk[k] = $signed(sumk[k]) + $signed({{(spi_pkg::PW-31){sm[k][31]}}, sm[k]});
      if (sumk[k][spi_pkg::PW:31] == '0 || sumk[k][spi_pkg::PW:31] == '1) begin
        satk[k] = sumk[k][31:0];
      end else if (sumk[k][spi_pkg::PW]) begin
        satk[k] = 32'h8000_0000;
      end else begin
        satk[k] = 32'h7FFF_FFFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    hf.hit_x    <= satk[0];
    hf.hit_y    <= satk[1];
    hf.hit_z    <= satk[2];
    hf.parallel <= pmr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      vm <= 1'b0;
      vf <= 1'b0;
    end else begin
      vc <= dv[spi_pkg::QB].v;
      vm <= vc;
      vf <= vm;
    end
  end

  // Result queue with a registered read into the output register.
  spi_pkg::hit_t            ram [spi_pkg::O_DEPTH];
  logic [spi_pkg::O_AW-1:0] wp, rp;
  logic [spi_pkg::O_AW:0]   rc;
  logic                     ov, load;

  assign load  = (rc != '0) && (!ov || out_pop);
  assign empty = !ov;

  always_ff @(posedge clk) begin
    if (vf) ram[wp] <= hf;
    if (load) hit <= ram[rp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      rc  <= '0;
      ov  <= 1'b0;
      tot <= '0;
    end else begin
      if (vf) wp <= wp + 1'b1;
      if (load) rp <= rp + 1'b1;
      rc  <= rc + (spi_pkg::O_AW+1)'(vf) - (spi_pkg::O_AW+1)'(load);
      if (load) ov <= 1'b1;
      else if (out_pop) ov <= 1'b0;
      tot <= tot + (spi_pkg::O_AW+1)'(q_pop) - (spi_pkg::O_AW+1)'(out_pop);
    end
  end

endmodule

FILE: rtl/segment_plane_intersect_top.sv
// Segment / plane intersection in signed Q16.16 fixed point.
// Top level; instantiates spi_front and spi_back, types from spi_pkg.
//
// The plane is set through the write port: wr_en, wr_index (0..2 normal x/y/z,
// 3..5 anchor point x/y/z) and wr_data. Writes to other indexes are ignored.
// Write the plane only while no item is in flight.
// An input item is a segment; it is taken when push is high and full is low.
// A result item sits on hit while empty is low and leaves when pop is high.
// One item per cycle is sustained while the receiver keeps popping. From push
// to empty going low an item passes the front stages (differences, products,
// sums, magnitudes and flags), the job queue, the range check, the pipelined
// divider (one quotient bit per stage), the clamp, multiply and saturation
// registers, and the result queue with its output register.
// When the receiver stalls, results gather in a 64-entry queue; each item in
// the back pipeline holds a place there, so once it is full the 8-entry job
// queue fills and full rises. Nothing is lost.
// Reset clears both queues and sets the plane to z = 0 with normal (0, 0, 1).
module segment_plane_intersect_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  spi_pkg::seg_t segment,
  output logic          empty,
  input  logic          pop,
  output spi_pkg::hit_t hit,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [31:0]   wr_data
);

  logic          q_pop;
  logic          q_empty;
  spi_pkg::job_t q_head;

  spi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .segment  (segment),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .q_pop    (q_pop),
    .q_empty  (q_empty),
    .q_head   (q_head)
  );

  spi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .hit     (hit)
  );

endmodule

FILE: sim/segment_plane_intersect_top_tb.sv
// Self-checking testbench for segment_plane_intersect_top: segments in, plane hits out.
// A scoreboard class predicts each hit in wide integer arithmetic; depends on spi_pkg.
`timescale 1ns / 1ps

module segment_plane_intersect_top_tb;

  localparam int F = spi_pkg::FRAC_BITS;
  localparam logic [2:0] REG_NONE = 3'd6;

  class hit_scoreboard;
    logic signed [31:0] normal [3];
    logic signed [31:0] anchor [3];
    spi_pkg::hit_t pending [$];
    int errors;

    function new();
      normal[0] = 0; normal[1] = 0; normal[2] = 32'sd1 <<< F;
      anchor[0] = 0; anchor[1] = 0; anchor[2] = 0;
      errors = 0;
    endfunction

    function void set_plane(logic [2:0] idx, logic [31:0] val);
      if (idx < 3) normal[idx] = val;
      else if (idx < 6) anchor[idx - 3] = val;
    endfunction

    function logic signed [31:0] clamp32(logic signed [127:0] v);
      if (v > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -128'sh80000000) return 32'sh80000000;
      return v[31:0];
    endfunction

    // Intersection of the segment's line with the plane, exact before clamping.
    function void note_segment(spi_pkg::seg_t sg);
      logic signed [127:0] s [3];
      logic signed [127:0] d [3];
      logic signed [127:0] num, den, t, p;
      logic [127:0] q;
      spi_pkg::hit_t h;
      s[0] = sg.start_x; s[1] = sg.start_y; s[2] = sg.start_z;
      d[0] = 128'(sg.end_x) - s[0];
      d[1] = 128'(sg.end_y) - s[1];
      d[2] = 128'(sg.end_z) - s[2];
      num = 0; den = 0; t = 0;
      for (int k = 0; k < 3; k++) begin
        num += 128'(normal[k]) * (128'(anchor[k]) - s[k]);
        den += 128'(normal[k]) * d[k];
      end
      h.parallel = (den == 0);
      if (!h.parallel) begin
        q = ((num < 0 ? -num : num) <<< F) / (den < 0 ? -den : den);
        if ((num < 0) != (den < 0)) t = (q > 128'h80000000) ? -128'sh80000000 : -$signed(q);
        else t = (q > 128'h7FFFFFFF) ? 128'sh7FFFFFFF : $signed(q);
      end
      p = ((t * d[0]) >>> F) + s[0]; h.hit_x = clamp32(p);
      p = ((t * d[1]) >>> F) + s[1]; h.hit_y = clamp32(p);
      p = ((t * d[2]) >>> F) + s[2]; h.hit_z = clamp32(p);
      pending.push_back(h);
    endfunction

    function void check_hit(spi_pkg::hit_t got);
      spi_pkg::hit_t want;
      if (pending.size() == 0) begin
        $error("hit item with nothing expected: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.hit_x !== want.hit_x) begin
        $error("hit_x: expected %0d, got %0d", want.hit_x, got.hit_x); errors++;
      end
      if (got.hit_y !== want.hit_y) begin
        $error("hit_y: expected %0d, got %0d", want.hit_y, got.hit_y); errors++;
      end
      if (got.hit_z !== want.hit_z) begin
        $error("hit_z: expected %0d, got %0d", want.hit_z, got.hit_z); errors++;
      end
      if (got.parallel !== want.parallel) begin
        $error("parallel: expected %0b, got %0b", want.parallel, got.parallel); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0, full, empty;
  spi_pkg::seg_t segment = '0;
  spi_pkg::hit_t hit;
  logic wr_en = 0;
  logic [2:0] wr_index = spi_pkg::REG_NORMAL_X;
  logic [31:0] wr_data = '0;

  int send_idle = 0, take_stall = 0;
  int hold_off = 0;
  hit_scoreboard sb = new();

  segment_plane_intersect_top dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Results are taken at the rising edge; pop is set up at the falling edge.
  always @(posedge clk) if (!rst && pop && !empty) sb.check_hit(hit);

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 0;
    end else begin
      pop <= ($urandom_range(99) >= take_stall);
    end
  end

  function logic [31:0] pick_coord();
    case ($urandom_range(7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(2047) - 1024;
      3: return ($urandom_range(255) - 128) <<< F;
      default: return $urandom();
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    wr_en <= 1; wr_index <= idx; wr_data <= val;
    sb.set_plane(idx, val);
    @(negedge clk);
    wr_en <= 0;
  endtask

  task automatic set_plane(logic [31:0] nx, ny, nz, ax, ay, az);
    write_reg(spi_pkg::REG_NORMAL_X, nx);
    write_reg(spi_pkg::REG_NORMAL_Y, ny);
    write_reg(spi_pkg::REG_NORMAL_Z, nz);
    write_reg(spi_pkg::REG_ANCHOR_X, ax);
    write_reg(spi_pkg::REG_ANCHOR_Y, ay);
    write_reg(spi_pkg::REG_ANCHOR_Z, az);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_segment(spi_pkg::seg_t sg);
    while ($urandom_range(99) < send_idle) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1; segment <= sg;
    do @(posedge clk); while (full);
    sb.note_segment(sg);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    push <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic random_segments(int count);
    spi_pkg::seg_t sg;
    for (int i = 0; i < count; i++) begin
      sg = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord()};
      if ($urandom_range(9) == 0) {sg.end_x, sg.end_y, sg.end_z} = {sg.start_x, sg.start_y, sg.start_z};
      send_segment(sg);
    end
    stop_sending();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 0;
    @(negedge clk);

    // Directed: reset plane z = 0, crossing, parallel, degenerate, extremes.
    send_segment({32'sd0, 32'sd0, -32'sd65536, 32'sd65536, 32'sd0, 32'sd65536});
    send_segment({32'sd5, 32'sd7, 32'sd65536, 32'sd9, 32'sd3, 32'sd65536});
    send_segment({32'sd5, 32'sd7, 32'sd100, 32'sd5, 32'sd7, 32'sd100});
    send_segment({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000});
    send_segment({32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
    send_segment({32'sd0, 32'sd0, 32'sd1, 32'h7FFFFFFF, 32'h80000000, 32'sd2});
    send_segment({32'h80000000, 32'sd0, 32'sd65536, 32'h7FFFFFFF, 32'sd0, 32'sd65535});
    send_segment({32'sd0, 32'sd0, 32'sd100, 32'sd0, 32'sd0, 32'sd101});
    send_segment({32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'sd0, 32'sd0, 32'sd0});
    stop_sending();
    drain();

    set_plane(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    write_reg(REG_NONE, 32'hDEADBEEF);
    write_reg(3'd7, 32'h12345678);
    send_segment({32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0});
    send_segment({32'h7FFFFFFF, 32'h80000000, 32'sd0, 32'h80000000, 32'h7FFFFFFF, 32'sd0});
    random_segments(10);
    drain();

    // Random phases across idling patterns and plane settings.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  take_stall = 0;  end
        1: begin send_idle = 72; take_stall = 0;  end
        2: begin send_idle = 0;  take_stall = 72; end
        default: begin send_idle = 35; take_stall = 35; end
      endcase
      set_plane($urandom_range(1) ? pick_coord() : 32'sd0, pick_coord(), pick_coord(),
                pick_coord(), pick_coord(), pick_coord());
      random_segments(75);
      drain();
      set_plane(($urandom_range(3) - 2) <<< F, ($urandom_range(3) - 1) <<< F,
                $urandom_range(65535), pick_coord(), pick_coord(), pick_coord());
      random_segments(75);
      drain();
    end

    // Long receiver hold-offs; in the second run the result queue fills and full rises.
    send_idle = 0; take_stall = 0;
    set_plane(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    hold_off = 300;
    random_segments(20);
    drain();
    set_plane(32'sd65536, 32'sd65536, 32'sd65536, 32'sd0, 32'sd0, 32'sd65536);
    hold_off = 300;
    random_segments(120);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("segment_plane_intersect_top regression: pass");
    else
      $display("segment_plane_intersect_top regression: fail");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("segment_plane_intersect_top regression: fail");
    $finish;
  end
endmodule
